@@ rtl/hsl_to_rgb_top_defines.svh @@
// ----------------------------------------------------------------------------
// hsl_to_rgb_top_defines
// assertion macros for the hsl to rgb converter, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef HSL_TO_RGB_TOP_DEFINES_SVH
`define HSL_TO_RGB_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define HSL_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hsl_to_rgb assertion failed");

`define HSL_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hsl_to_rgb reset assertion failed");

`else

`define HSL_ASSERT(lbl, clk, rst, prop)

`define HSL_ASSERT_RST(lbl, clk, prop)

`endif

`endif

@@ rtl/hsl_pkg.sv @@
// ----------------------------------------------------------------------------
// hsl_pkg
// widths, hue constants and shared types of the hsl to rgb converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hsl_pkg;

  localparam int FRAC_W     = 16;
  localparam int HUE_W      = FRAC_W;
  localparam int LVL_W      = FRAC_W + 1;
  localparam int SUM_W      = LVL_W + 1;
  localparam int T6_W       = FRAC_W + 1;
  localparam int PROD_W     = LVL_W + T6_W;
  localparam int LEVEL_W    = PROD_W - FRAC_W;
  localparam int BYTE_W     = 8;
  localparam int SCALE_W    = LEVEL_W + BYTE_W;
  localparam int TOP_W      = SCALE_W - FRAC_W;
  localparam int LVL_STAGES = 4;
  localparam int CH_STAGES  = 4;
  localparam int PIPE_DEPTH = LVL_STAGES + CH_STAGES;

  localparam longint ONE_I = 64'd1 << FRAC_W;

  localparam logic [LVL_W-1:0] ONE        = LVL_W'(ONE_I);
  localparam logic [LVL_W-1:0] HALF_L     = LVL_W'(ONE_I / 2);
  localparam logic [HUE_W-1:0] THIRD      = HUE_W'(ONE_I / 3);
  localparam logic [HUE_W-1:0] SIXTH      = HUE_W'((ONE_I + 3) / 6);
  localparam logic [HUE_W-1:0] HALF_H     = HUE_W'(ONE_I / 2);
  localparam logic [HUE_W-1:0] TWO_THIRDS = HUE_W'((2 * ONE_I + 1) / 3);
  localparam logic [BYTE_W-1:0] BYTE_MAX  = {BYTE_W{1'b1}};

  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } seg_t;

  typedef struct packed {
    logic [LVL_W-1:0] lo;
    logic [LVL_W-1:0] hi;
  } lvl_t;

endpackage

@@ rtl/hsl_to_rgb_top.sv @@
// ----------------------------------------------------------------------------
// hsl_to_rgb_top
// converts one hue/saturation/lightness word to one rgb word of three 8-bit channels
// throughput: one word per cycle unless the output is held, set by the 8-stage pipeline
// a held output stalls the whole pipeline in place
// reset clears all valid bits, datapath registers are not reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hsl_to_rgb_top_defines.svh"

module hsl_to_rgb_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       hsl_valid,
  output logic                       hsl_stall,
  input  logic [hsl_pkg::HUE_W-1:0]  hue,
  input  logic [hsl_pkg::LVL_W-1:0]  saturation,
  input  logic [hsl_pkg::LVL_W-1:0]  lightness,
  output logic                       rgb_valid,
  input  logic                       rgb_stall,
  output logic [hsl_pkg::BYTE_W-1:0] red,
  output logic [hsl_pkg::BYTE_W-1:0] green,
  output logic [hsl_pkg::BYTE_W-1:0] blue
);
  import hsl_pkg::*;

  logic [PIPE_DEPTH-1:0] vld;
  logic                  en;
  lvl_t                  lvl;
  logic [HUE_W-1:0]      t_red, t_green, t_blue;

  assign en        = !(vld[PIPE_DEPTH-1] && rgb_stall);
  assign hsl_stall = rst || !en;
  assign rgb_valid = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], hsl_valid};
    end
  end

  hsl_levels u_levels (
    .clk        (clk),
    .en         (en),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness),
    .lvl        (lvl),
    .t_red      (t_red),
    .t_green    (t_green),
    .t_blue     (t_blue)
  );

  hsl_chan u_red (
    .clk  (clk),
    .en   (en),
    .t    (t_red),
    .lvl  (lvl),
    .chan (red)
  );

  hsl_chan u_green (
    .clk  (clk),
    .en   (en),
    .t    (t_green),
    .lvl  (lvl),
    .chan (green)
  );

  hsl_chan u_blue (
    .clk  (clk),
    .en   (en),
    .t    (t_blue),
    .lvl  (lvl),
    .chan (blue)
  );

  `HSL_ASSERT(a_held_out_stalls_in, clk, rst, (rgb_valid && rgb_stall) |-> hsl_stall)
  `HSL_ASSERT(a_free_out_frees_in, clk, rst, !rgb_stall |-> !hsl_stall)
  `HSL_ASSERT(a_empty_pipe_no_out, clk, rst, (!en == 1'b0 && vld == '0) |=> !rgb_valid)
  `HSL_ASSERT_RST(a_reset_clears_out, clk, rst |=> !rgb_valid)

endmodule

@@ rtl/hsl_levels.sv @@
// ----------------------------------------------------------------------------
// hsl_levels
// four-stage front end: clamps inputs, forms the low and high levels and
// the hue position of each channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsl_levels (
  input  logic                      clk,
  input  logic                      en,
  input  logic [hsl_pkg::HUE_W-1:0] hue,
  input  logic [hsl_pkg::LVL_W-1:0] saturation,
  input  logic [hsl_pkg::LVL_W-1:0] lightness,
  output hsl_pkg::lvl_t             lvl,
  output logic [hsl_pkg::HUE_W-1:0] t_red,
  output logic [hsl_pkg::HUE_W-1:0] t_green,
  output logic [hsl_pkg::HUE_W-1:0] t_blue
);
  import hsl_pkg::*;

  logic [LVL_W-1:0]   s1, l1, s2, l2, ls2, l3;
  logic [HUE_W-1:0]   tr1, tg1, tb1, tr2, tg2, tb2, tr3, tg3, tb3;
  logic [2*LVL_W-1:0] ls_full;
  logic [SUM_W-1:0]   q_sum, q3, twol, p_val, q_val;

  // stage 1: clamp and hue offsets
  always_ff @(posedge clk) begin
    if (en) begin
      s1  <= (saturation > ONE) ? ONE : saturation;
      l1  <= (lightness > ONE) ? ONE : lightness;
      tr1 <= hue + THIRD;
      tg1 <= hue;
      tb1 <= hue - THIRD;
    end
  end

  // stage 2: l * s
  assign ls_full = (2*LVL_W)'(l1) * (2*LVL_W)'(s1);

  always_ff @(posedge clk) begin
    if (en) begin
      ls2 <= ls_full[FRAC_W +: LVL_W];
      l2  <= l1;
      s2  <= s1;
      tr2 <= tr1;
      tg2 <= tg1;
      tb2 <= tb1;
    end
  end

  // stage 3: high level
  always_comb begin
    if (l2 < HALF_L) begin
      q_sum = SUM_W'(l2) + SUM_W'(ls2);
    end else begin
      q_sum = SUM_W'(l2) + SUM_W'(s2) - SUM_W'(ls2);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q3  <= q_sum;
      l3  <= l2;
      tr3 <= tr2;
      tg3 <= tg2;
      tb3 <= tb2;
    end
  end

  // stage 4: low level
  assign twol  = {l3, 1'b0};
  assign p_val = (twol >= q3) ? twol - q3 : '0;
  assign q_val = (q3 < p_val) ? p_val : q3;

  always_ff @(posedge clk) begin
    if (en) begin
      lvl.lo  <= p_val[LVL_W-1:0];
      lvl.hi  <= q_val[LVL_W-1:0];
      t_red   <= tr3;
      t_green <= tg3;
      t_blue  <= tb3;
    end
  end

endmodule

@@ rtl/hsl_chan.sv @@
// ----------------------------------------------------------------------------
// hsl_chan
// four-stage channel back end: segment decode, ramp multiply, level select
// and scaling to one output byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsl_chan (
  input  logic                       clk,
  input  logic                       en,
  input  logic [hsl_pkg::HUE_W-1:0]  t,
  input  hsl_pkg::lvl_t              lvl,
  output logic [hsl_pkg::BYTE_W-1:0] chan
);
  import hsl_pkg::*;

  seg_t               seg_next, seg5, seg6;
  logic [HUE_W-1:0]   fall_t, ramp_t;
  logic [T6_W-1:0]    t6_next, t65;
  logic [LVL_W-1:0]   span5, lo5, hi5, lo6, hi6;
  logic [PROD_W-1:0]  prod6;
  logic [LEVEL_W-1:0] ramp, level_next, level7;
  logic [SCALE_W-1:0] scaled;
  logic [TOP_W-1:0]   scaled_top;

  // stage 5: segment and ramp factor
  assign fall_t = TWO_THIRDS - t;

  always_comb begin
    seg_next = SEG_LOW;
    ramp_t   = '0;
    if (t < SIXTH) begin
      seg_next = SEG_RISE;
      ramp_t   = t;
    end else if (t < HALF_H) begin
      seg_next = SEG_HIGH;
    end else if (t < TWO_THIRDS) begin
      seg_next = SEG_FALL;
      ramp_t   = fall_t;
    end
    t6_next = (T6_W'(ramp_t) << 2) + (T6_W'(ramp_t) << 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg5  <= seg_next;
      t65   <= t6_next;
      span5 <= lvl.hi - lvl.lo;
      lo5   <= lvl.lo;
      hi5   <= lvl.hi;
    end
  end

  // stage 6: ramp product
  always_ff @(posedge clk) begin
    if (en) begin
      prod6 <= PROD_W'(span5) * PROD_W'(t65);
      seg6  <= seg5;
      lo6   <= lo5;
      hi6   <= hi5;
    end
  end

  // stage 7: level select
  assign ramp = prod6[PROD_W-1:FRAC_W];

  always_comb begin
    case (seg6)
      SEG_RISE: level_next = LEVEL_W'(lo6) + ramp;
      SEG_FALL: level_next = LEVEL_W'(lo6) + ramp;
      SEG_HIGH: level_next = LEVEL_W'(hi6);
      default:  level_next = LEVEL_W'(lo6);
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      level7 <= level_next;
    end
  end

  // stage 8: times 255, drop fraction, saturate
  assign scaled     = (SCALE_W'(level7) << BYTE_W) - SCALE_W'(level7);
  assign scaled_top = scaled[SCALE_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (en) begin
      chan <= (scaled_top > TOP_W'(BYTE_MAX)) ? BYTE_MAX : scaled_top[BYTE_W-1:0];
    end
  end

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for hsl_to_rgb_top: a table of directed hsl words and
// then random words are pushed through the valid/stall handshake, with random
// gaps on the sender and random stalls on the receiver. every rgb word out is
// compared per field with its table value or a bit-exact color predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int FRAC = 16;
  localparam longint unsigned UNIT = 64'd1 << FRAC;
  localparam longint unsigned TURN_THIRD = UNIT / 3;
  localparam longint unsigned RISE_END = (UNIT + 3) / 6;
  localparam longint unsigned PLATEAU_END = UNIT / 2;
  localparam longint unsigned FALL_END = (2 * UNIT + 1) / 3;
  localparam longint unsigned LEVEL_MAX = 17'h1ffff;
  localparam int DIRECTED_ROWS = 24;
  localparam int RANDOM_WORDS = 1880;
  localparam int DRAIN_AT = 1000;
  localparam int GAP_MAX = 11;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX = 50;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_word_t;

  typedef struct packed {
    logic [hsl_pkg::HUE_W-1:0] hue;
    logic [hsl_pkg::LVL_W-1:0] sat;
    logic [hsl_pkg::LVL_W-1:0] lit;
    logic fixed_rgb;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } stim_row_t;

  logic clk;
  logic rst = 1'b1;
  logic hsl_valid = 1'b0;
  logic hsl_stall;
  logic [hsl_pkg::HUE_W-1:0] hue = '0;
  logic [hsl_pkg::LVL_W-1:0] saturation = '0;
  logic [hsl_pkg::LVL_W-1:0] lightness = '0;
  logic rgb_valid;
  logic rgb_stall = 1'b0;
  logic [hsl_pkg::BYTE_W-1:0] red;
  logic [hsl_pkg::BYTE_W-1:0] green;
  logic [hsl_pkg::BYTE_W-1:0] blue;

  rgb_word_t rgb_expect_q[$];
  stim_row_t directed_rows [DIRECTED_ROWS];
  logic [hsl_pkg::HUE_W-1:0] hue_marks [6];

  int error_count = 0;
  int cycle_count = 0;
  int words_sent = 0;
  int words_checked = 0;
  int rgb_seen = 0;
  int grey_words = 0;
  int clamped_words = 0;
  bit steady_send = 1'b0;
  bit steady_recv = 1'b0;

  hsl_to_rgb_top dut (
    .clk(clk),
    .rst(rst),
    .hsl_valid(hsl_valid),
    .hsl_stall(hsl_stall),
    .hue(hue),
    .saturation(saturation),
    .lightness(lightness),
    .rgb_valid(rgb_valid),
    .rgb_stall(rgb_stall),
    .red(red),
    .green(green),
    .blue(blue)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, rgb_expect_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  // one channel: piecewise linear level over its hue position, then to a byte
  function automatic logic [7:0] channel_byte(longint unsigned t, longint unsigned lo,
                                              longint unsigned hi);
    longint unsigned span;
    longint unsigned level;
    longint unsigned scaled;
    span = hi - lo;
    if (t < RISE_END)
      level = lo + ((6 * span * t) >> FRAC);
    else if (t < PLATEAU_END)
      level = hi;
    else if (t < FALL_END)
      level = lo + ((6 * span * (FALL_END - t)) >> FRAC);
    else
      level = lo;
    scaled = (level * 255) >> FRAC;
    return (scaled > 255) ? 8'hff : scaled[7:0];
  endfunction

  function automatic rgb_word_t hsl_color(logic [hsl_pkg::HUE_W-1:0] h,
                                          logic [hsl_pkg::LVL_W-1:0] sat,
                                          logic [hsl_pkg::LVL_W-1:0] lit);
    longint unsigned s;
    longint unsigned l;
    longint unsigned ls;
    longint unsigned q;
    longint unsigned p;
    longint unsigned hh;
    rgb_word_t c;
    s = (sat > UNIT) ? UNIT : sat;
    l = (lit > UNIT) ? UNIT : lit;
    hh = h;
    ls = (l * s) >> FRAC;
    q = (l < PLATEAU_END) ? l + ls : l + s - ls;
    p = (2 * l >= q) ? 2 * l - q : 0;
    if (q < p)
      q = p;
    c.red = channel_byte((hh + TURN_THIRD) & (UNIT - 1), p, q);
    c.green = channel_byte(hh, p, q);
    c.blue = channel_byte((hh + UNIT - TURN_THIRD) & (UNIT - 1), p, q);
    return c;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    if (error_count <= REPORT_MAX)
      $display("mismatch: %s got %0d expected %0d (rgb word %0d, t=%0t)",
               what, got, want, rgb_seen, $time);
  endtask

  task automatic send_word(logic [hsl_pkg::HUE_W-1:0] h, logic [hsl_pkg::LVL_W-1:0] s,
                           logic [hsl_pkg::LVL_W-1:0] l, rgb_word_t want);
    int gap;
    gap = steady_send ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      hsl_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    hsl_valid <= 1'b1;
    hue <= h;
    saturation <= s;
    lightness <= l;
    @(posedge clk);
    while (hsl_stall) @(posedge clk);
    rgb_expect_q.push_back(want);
    words_sent++;
    if (s == 0)
      grey_words++;
    if (s > UNIT || l > UNIT)
      clamped_words++;
  endtask

  task automatic drain_pipeline();
    hsl_valid <= 1'b0;
    @(posedge clk);
    while (rgb_expect_q.size() != 0) @(posedge clk);
  endtask

  // rgb side: random stalls, compare each accepted word with the oldest expected
  initial begin : rgb_sink
    int wait_cycles;
    rgb_word_t want;
    while (rst) @(posedge clk);
    forever begin
      if (rgb_seen % 64 == 0)
        steady_recv = ($urandom_range(0, 3) == 0);
      wait_cycles = steady_recv ? 0 : $urandom_range(0, GAP_MAX);
      if (wait_cycles > 0) begin
        rgb_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
        rgb_stall <= 1'b0;
      end
      @(posedge clk);
      while (!rgb_valid) @(posedge clk);
      rgb_seen++;
      if (rgb_expect_q.size() == 0) begin
        report_mismatch("unexpected rgb word, red", red, 0);
      end else begin
        want = rgb_expect_q.pop_front();
        words_checked++;
        if (red !== want.red)
          report_mismatch("red", red, want.red);
        if (green !== want.green)
          report_mismatch("green", green, want.green);
        if (blue !== want.blue)
          report_mismatch("blue", blue, want.blue);
      end
    end
  end

  initial begin : hsl_source
    stim_row_t row;
    rgb_word_t want;
    logic [hsl_pkg::HUE_W-1:0] h;
    logic [hsl_pkg::LVL_W-1:0] s;
    logic [hsl_pkg::LVL_W-1:0] l;

    directed_rows = '{
      '{16'd0, 17'd0, 17'd0, 1'b1, 8'd0, 8'd0, 8'd0},
      '{16'd65535, 17'd65536, 17'd65536, 1'b1, 8'd255, 8'd255, 8'd255},
      '{16'd4660, 17'd0, 17'd32768, 1'b1, 8'd127, 8'd127, 8'd127},
      '{16'd0, 17'd65536, 17'd32768, 1'b1, 8'd255, 8'd0, 8'd0},
      '{16'd32768, 17'd65536, 17'd32768, 1'b1, 8'd0, 8'd255, 8'd255},
      '{16'd0, 17'd131071, 17'd131071, 1'b1, 8'd255, 8'd255, 8'd255},
      '{16'd0, 17'd65537, 17'd32768, 1'b1, 8'd255, 8'd0, 8'd0},
      '{16'd0, 17'd131071, 17'd0, 1'b1, 8'd0, 8'd0, 8'd0},
      '{16'd21845, 17'd65536, 17'd32768, 1'b0, 8'd0, 8'd0, 8'd0},
      '{16'd43691, 17'd65536, 17'd32768, 1'b0, 8'd0, 8'd0, 8'd0},
      '{16'd10922, 17'd65536, 17'd32768, 1'b0, 8'd0, 8'd0, 8'd0},
      '{16'd10923, 17'd65536, 17'd32768, 1'b0, 8'd0, 8'd0, 8'd0},
      '{16'd32767, 17'd65536, 17'd32768, 1'b0, 8'd0, 8'd0, 8'd0},
      '{16'd43690, 17'd65536, 17'd32768, 1'b0, 8'd0, 8'd0, 8'd0},
      '{16'd65535, 17'd65536, 17'd32768, 1'b0, 8'd0, 8'd0, 8'd0},
      '{16'd54613, 17'd65536, 17'd32768, 1'b0, 8'd0, 8'd0, 8'd0},
      '{16'd1, 17'd65536, 17'd32768, 1'b0, 8'd0, 8'd0, 8'd0},
      '{16'd5000, 17'd40000, 17'd32767, 1'b0, 8'd0, 8'd0, 8'd0},
      '{16'd5000, 17'd40000, 17'd32769, 1'b0, 8'd0, 8'd0, 8'd0},
      '{16'd20000, 17'd65535, 17'd65535, 1'b0, 8'd0, 8'd0, 8'd0},
      '{16'd60000, 17'd1, 17'd1, 1'b0, 8'd0, 8'd0, 8'd0},
      '{16'haaaa, 17'h15555, 17'h0aaaa, 1'b0, 8'd0, 8'd0, 8'd0},
      '{16'h5555, 17'h0aaaa, 17'h15555, 1'b0, 8'd0, 8'd0, 8'd0},
      '{16'd30000, 17'd98304, 17'd16384, 1'b0, 8'd0, 8'd0, 8'd0}
    };
    hue_marks = '{16'd0, RISE_END[15:0], TURN_THIRD[15:0], PLATEAU_END[15:0],
                  FALL_END[15:0], 16'(PLATEAU_END + RISE_END)};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = directed_rows[i];
      if (row.fixed_rgb)
        want = {row.red, row.green, row.blue};
      else
        want = hsl_color(row.hue, row.sat, row.lit);
      send_word(row.hue, row.sat, row.lit, want);
    end

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 100 == 0)
        steady_send = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0)
        h = hue_marks[$urandom_range(0, 5)] + 16'($urandom_range(0, 4)) - 16'd2;
      else
        h = 16'($urandom);
      case ($urandom_range(0, 9))
        0: s = '0;
        1: s = UNIT[16:0];
        2: s = 17'($urandom_range(UNIT + 1, LEVEL_MAX));
        default: s = 17'($urandom_range(0, UNIT));
      endcase
      case ($urandom_range(0, 9))
        0: l = '0;
        1: l = UNIT[16:0];
        2: l = 17'($urandom_range(UNIT + 1, LEVEL_MAX));
        3: l = 17'($urandom_range(PLATEAU_END - 3, PLATEAU_END + 3));
        default: l = 17'($urandom_range(0, UNIT));
      endcase
      send_word(h, s, l, hsl_color(h, s, l));
      // hold off until the pipeline is empty, then resume
      if (i == DRAIN_AT)
        drain_pipeline();
    end

    hsl_valid <= 1'b0;
    while (rgb_expect_q.size() != 0) @(posedge clk);
    repeat (4 * hsl_pkg::PIPE_DEPTH) @(posedge clk);

    $display("sent %0d hsl words: %0d from the table, %0d grey, %0d with clamped levels",
             words_sent, DIRECTED_ROWS, grey_words, clamped_words);
    $display("checked %0d rgb words under random gaps and stalls, %0d mismatches",
             words_checked, error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/hsl_pkg.sv
rtl/hsl_levels.sv
rtl/hsl_chan.sv
rtl/hsl_to_rgb_top.sv
sim/tb.sv
